### hw/rtl/wgc_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// Wave grid cell update package
// Shared constants, codes and the command and status types that join the
// controller to the datapath.
// -----------------------------------------------------------------------------
package wgc_pkg;

  localparam int COL_BITS   = 7;
  localparam int ROW_BITS   = 7;
  localparam int VAL_BITS   = 16;
  localparam int VEL_BITS   = 13;
  localparam int DAMP_BITS  = 9;
  localparam int MASK_BITS  = 12;
  localparam int KIND_BITS  = 2;
  localparam int ADDR_BITS  = 1 + ROW_BITS + COL_BITS;
  localparam int BOARD_DEPTH = 1 << ADDR_BITS;

  localparam logic [KIND_BITS-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_UPDATE = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_SWAP   = 2'd2;
  localparam logic [KIND_BITS-1:0] KIND_POKE   = 2'd3;

  localparam logic REG_DAMPING = 1'b0;
  localparam logic REG_MASK    = 1'b1;

  localparam logic [2:0] SEL_CENTRE = 3'd0;
  localparam logic [2:0] SEL_UP     = 3'd1;
  localparam logic [2:0] SEL_LEFT   = 3'd2;
  localparam logic [2:0] SEL_DOWN   = 3'd3;
  localparam logic [2:0] SEL_RIGHT  = 3'd4;

  typedef struct packed {
    logic       accept;
    logic       exec;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       st_diff;
    logic       st_mult_v;
    logic       st_clamp;
    logic       st_sum_t;
    logic       st_mult_t;
    logic       st_final;
    logic       commit;
  } wgc_cmd_t;

  typedef struct packed {
    logic                 out_busy;
    logic [KIND_BITS-1:0] kind;
  } wgc_status_t;

endpackage
`default_nettype wire

### hw/rtl/wgc_ram.sv
`default_nettype none
// -----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, write or registered read.
// -----------------------------------------------------------------------------
module wgc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/wgc_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// Wave grid controller
// Sequences the dispatch, reads, arithmetic stages and the write-back for one word.
// -----------------------------------------------------------------------------
module wgc_ctrl import wgc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire wgc_status_t status,
  output wgc_cmd_t         cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_EXEC   = 4'd1;
  localparam logic [3:0] ST_RD_C   = 4'd2;
  localparam logic [3:0] ST_RD_U   = 4'd3;
  localparam logic [3:0] ST_RD_L   = 4'd4;
  localparam logic [3:0] ST_RD_D   = 4'd5;
  localparam logic [3:0] ST_RD_R   = 4'd6;
  localparam logic [3:0] ST_WAIT   = 4'd7;
  localparam logic [3:0] ST_DIFF   = 4'd8;
  localparam logic [3:0] ST_MULT_V = 4'd9;
  localparam logic [3:0] ST_CLAMP  = 4'd10;
  localparam logic [3:0] ST_SUM_T  = 4'd11;
  localparam logic [3:0] ST_MULT_T = 4'd12;
  localparam logic [3:0] ST_FINAL  = 4'd13;
  localparam logic [3:0] ST_WRITE  = 4'd14;

  logic [3:0] state, state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.kind == KIND_UPDATE) begin
          state_next = ST_RD_C;
        end else begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_RD_C: begin
        cmd.rd_en = 1'b1; cmd.rd_sel = SEL_CENTRE; state_next = ST_RD_U;
      end
      ST_RD_U: begin
        cmd.rd_en = 1'b1; cmd.rd_sel = SEL_UP; state_next = ST_RD_L;
      end
      ST_RD_L: begin
        cmd.rd_en = 1'b1; cmd.rd_sel = SEL_LEFT; state_next = ST_RD_D;
      end
      ST_RD_D: begin
        cmd.rd_en = 1'b1; cmd.rd_sel = SEL_DOWN; state_next = ST_RD_R;
      end
      ST_RD_R: begin
        cmd.rd_en = 1'b1; cmd.rd_sel = SEL_RIGHT; state_next = ST_WAIT;
      end
      ST_WAIT:   state_next = ST_DIFF;
      ST_DIFF: begin
        cmd.st_diff = 1'b1; state_next = ST_MULT_V;
      end
      ST_MULT_V: begin
        cmd.st_mult_v = 1'b1; state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.st_clamp = 1'b1; state_next = ST_SUM_T;
      end
      ST_SUM_T: begin
        cmd.st_sum_t = 1'b1; state_next = ST_MULT_T;
      end
      ST_MULT_T: begin
        cmd.st_mult_t = 1'b1; state_next = ST_FINAL;
      end
      ST_FINAL: begin
        cmd.st_final = 1'b1; state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (!status.out_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/wgc_datapath.sv
`default_nettype none
// -----------------------------------------------------------------------------
// Wave grid datapath
// Board memories, item and configuration registers, stencil arithmetic and
// the output register.
// -----------------------------------------------------------------------------
module wgc_datapath import wgc_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire wgc_cmd_t                    cmd,
  output wgc_status_t                      status,
  input  wire logic [KIND_BITS-1:0]        kind,
  input  wire logic [COL_BITS-1:0]         col,
  input  wire logic [ROW_BITS-1:0]         row,
  input  wire logic signed [VAL_BITS-1:0]  cell_value,
  input  wire logic signed [VAL_BITS-1:0]  cell_velocity,
  input  wire logic                        cfg_valid,
  input  wire logic                        cfg_index,
  input  wire logic [MASK_BITS-1:0]        cfg_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [MASK_BITS-1:0]             pixel_index,
  output logic signed [VAL_BITS-1:0]       new_value,
  output logic signed [VEL_BITS-1:0]       new_velocity,
  output logic [COL_BITS-1:0]              out_col,
  output logic [ROW_BITS-1:0]              out_row
);

  localparam logic signed [19:0] SAT_HI = 20'sd32767;
  localparam logic signed [19:0] SAT_LO = -20'sd32768;

  logic                        bank;
  logic signed [DAMP_BITS-1:0] damp;
  logic [MASK_BITS-1:0]        mask;

  logic [KIND_BITS-1:0]        kind_q;
  logic [COL_BITS-1:0]         col_q;
  logic [ROW_BITS-1:0]         row_q;
  logic signed [VAL_BITS-1:0]  ld_val;
  logic signed [VAL_BITS-1:0]  ld_vel;

  logic                        rd_vld;
  logic [2:0]                  rd_sel_q;
  logic signed [VAL_BITS-1:0]  centre;
  logic signed [VAL_BITS-1:0]  vel_old;
  logic signed [17:0]          sum;
  logic signed [17:0]          v0;
  logic signed [26:0]          prod_v;
  logic signed [VEL_BITS-1:0]  v_cl;
  logic signed [16:0]          t;
  logic signed [25:0]          prod_t;
  logic signed [VAL_BITS-1:0]  nv;
  logic [MASK_BITS-1:0]        pix;

  logic [COL_BITS-1:0]         rd_col;
  logic [ROW_BITS-1:0]         rd_row;
  logic [ADDR_BITS-1:0]        rd_addr, wr_addr, val_addr, vel_addr;
  logic                        val_we, vel_we;
  logic [VAL_BITS-1:0]         val_wdata, vel_wdata;
  logic [VAL_BITS-1:0]         val_rdata, vel_rdata;

  logic signed [16:0]          diff;
  logic signed [18:0]          v1;
  logic signed [18:0]          mask_pos, mask_neg;
  logic signed [19:0]          t_damped;

  // Neighbour coordinates wrap on the torus by plain modular arithmetic.
  always_comb begin
    rd_col = col_q;
    rd_row = row_q;
    unique case (cmd.rd_sel)
      SEL_UP:    rd_row = row_q - 1'b1;
      SEL_DOWN:  rd_row = row_q + 1'b1;
      SEL_LEFT:  rd_col = col_q - 1'b1;
      SEL_RIGHT: rd_col = col_q + 1'b1;
      default:   ;
    endcase
  end

  assign rd_addr = {bank, rd_row, rd_col};
  assign wr_addr = {(kind_q == KIND_LOAD) ? bank : ~bank, row_q, col_q};

  always_comb begin
    val_we    = 1'b0;
    vel_we    = 1'b0;
    val_wdata = nv;
    vel_wdata = {{(VAL_BITS-VEL_BITS){v_cl[VEL_BITS-1]}}, v_cl};
    if (cmd.exec && kind_q == KIND_LOAD) begin
      val_we    = 1'b1;
      vel_we    = 1'b1;
      val_wdata = ld_val;
      vel_wdata = ld_vel;
    end else if (cmd.exec && kind_q == KIND_POKE) begin
      val_we    = 1'b1;
      val_wdata = {{(VAL_BITS-MASK_BITS){1'b0}}, mask};
    end else if (cmd.commit) begin
      val_we = 1'b1;
      vel_we = 1'b1;
    end
  end

  assign val_addr = val_we ? wr_addr : rd_addr;
  assign vel_addr = vel_we ? wr_addr : rd_addr;

  wgc_ram #(.WIDTH(VAL_BITS), .DEPTH(BOARD_DEPTH)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .addr  (val_addr),
    .wdata (val_wdata),
    .rdata (val_rdata)
  );

  wgc_ram #(.WIDTH(VAL_BITS), .DEPTH(BOARD_DEPTH)) u_velocity_ram (
    .clk   (clk),
    .we    (vel_we),
    .addr  (vel_addr),
    .wdata (vel_wdata),
    .rdata (vel_rdata)
  );

  // Arithmetic between the stage registers.
  assign diff     = 17'(sum >>> 2) - 17'(centre);
  assign v1       = 19'(v0) + 19'(prod_v >>> 8);
  assign mask_pos = 19'($signed({1'b0, mask}));
  assign mask_neg = -mask_pos;
  assign t_damped = 20'(t) + 20'(prod_t >>> 8);

  always_ff @(posedge clk) begin
    if (rst) begin
      bank      <= 1'b0;
      damp      <= '0;
      mask      <= MASK_BITS'(255);
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_DAMPING) begin
          damp <= cfg_data[DAMP_BITS-1:0];
        end else begin
          mask <= cfg_data;
        end
      end
      if (cmd.exec && kind_q == KIND_SWAP) begin
        bank <= ~bank;
      end
      rd_vld <= cmd.rd_en;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q <= kind;
      col_q  <= col;
      row_q  <= row;
      ld_val <= cell_value;
      ld_vel <= cell_velocity;
      sum    <= '0;
    end
    rd_sel_q <= cmd.rd_sel;
    if (rd_vld) begin
      if (rd_sel_q == SEL_CENTRE) begin
        centre  <= val_rdata;
        vel_old <= vel_rdata;
      end else begin
        sum <= sum + 18'($signed(val_rdata));
      end
    end
    if (cmd.st_diff) begin
      v0 <= 18'(vel_old) + 18'(diff >>> 2);
    end
    if (cmd.st_mult_v) begin
      prod_v <= v0 * damp;
    end
    if (cmd.st_clamp) begin
      if (v1 > mask_pos) begin
        v_cl <= mask_pos[VEL_BITS-1:0];
      end else if (v1 < mask_neg) begin
        v_cl <= mask_neg[VEL_BITS-1:0];
      end else begin
        v_cl <= v1[VEL_BITS-1:0];
      end
    end
    if (cmd.st_sum_t) begin
      t <= 17'(centre) + 17'(v_cl);
    end
    if (cmd.st_mult_t) begin
      prod_t <= t * damp;
    end
    if (cmd.st_final) begin
      if (t_damped > SAT_HI) begin
        nv <= SAT_HI[VAL_BITS-1:0];
      end else if (t_damped < SAT_LO) begin
        nv <= SAT_LO[VAL_BITS-1:0];
      end else begin
        nv <= t_damped[VAL_BITS-1:0];
      end
      pix <= (t[MASK_BITS-1:0] + {2'b00, mask[MASK_BITS-1:2]}) & mask;
    end
    if (cmd.commit) begin
      pixel_index  <= pix;
      new_value    <= nv;
      new_velocity <= v_cl;
      out_col      <= col_q;
      out_row      <= row_q;
    end
  end

  assign status.out_busy = out_valid & out_stall;
  assign status.kind     = kind_q;

endmodule
`default_nettype wire

### hw/rtl/wave_grid_cell_update_unit.sv
`default_nettype none
// -----------------------------------------------------------------------------
// Wave grid cell update unit
// Load, swap and poke words are carried out in the dispatch step and yield no
// result word. An update passes through the dispatch step, five value reads
// through one single-port board memory, a wait state for the last read to
// return, six arithmetic stages and the write-back. No new word is taken until
// the current one is done. An update waits at write-back while an earlier
// result is still held. Synchronous reset returns to idle, selects board 0,
// and sets damping to 0 and the level mask to 255.
// -----------------------------------------------------------------------------
module wave_grid_cell_update_unit import wgc_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Input word channel.
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [KIND_BITS-1:0]        kind,
  input  wire logic [COL_BITS-1:0]         col,
  input  wire logic [ROW_BITS-1:0]         row,
  input  wire logic signed [VAL_BITS-1:0]  cell_value,
  input  wire logic signed [VAL_BITS-1:0]  cell_velocity,
  // Configuration write channel.
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic                        cfg_index,
  input  wire logic [MASK_BITS-1:0]        cfg_data,
  // Result word channel.
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [MASK_BITS-1:0]             pixel_index,
  output logic signed [VAL_BITS-1:0]       new_value,
  output logic signed [VEL_BITS-1:0]       new_velocity,
  output logic [COL_BITS-1:0]              out_col,
  output logic [ROW_BITS-1:0]              out_row
);

  // The controller walks each word through its steps: a dispatch cycle that
  // performs a load, poke or swap directly, or for an update five reads of
  // the source board (centre with its velocity, then the four wrapped
  // neighbours), followed by the arithmetic stages and a write-back to the
  // destination board. The result word sits in an output register, so the
  // next input word is taken while it waits; only a second update that
  // reaches write-back before the first result is taken has to hold.

  wgc_cmd_t    cmd;
  wgc_status_t status;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  wgc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  wgc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .kind          (kind),
    .col           (col),
    .row           (row),
    .cell_value    (cell_value),
    .cell_velocity (cell_velocity),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_index   (pixel_index),
    .new_value     (new_value),
    .new_velocity  (new_velocity),
    .out_col       (out_col),
    .out_row       (out_row)
  );

endmodule
`default_nettype wire

### sim/wave_grid_cell_update_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Wave grid cell update checker
// Watches the word, result and configuration channels, keeps its own copy of
// both boards and the registers, predicts each update result and compares it
// field by field with what the unit returns.
// -----------------------------------------------------------------------------
module wave_grid_cell_update_checker import wgc_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire logic [KIND_BITS-1:0]       kind,
  input  wire logic [COL_BITS-1:0]        col,
  input  wire logic [ROW_BITS-1:0]        row,
  input  wire logic signed [VAL_BITS-1:0] cell_value,
  input  wire logic signed [VAL_BITS-1:0] cell_velocity,
  input  wire logic                       cfg_valid,
  input  wire logic                       cfg_ready,
  input  wire logic                       cfg_index,
  input  wire logic [MASK_BITS-1:0]       cfg_data,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire logic [MASK_BITS-1:0]       pixel_index,
  input  wire logic signed [VAL_BITS-1:0] new_value,
  input  wire logic signed [VEL_BITS-1:0] new_velocity,
  input  wire logic [COL_BITS-1:0]        out_col,
  input  wire logic [ROW_BITS-1:0]        out_row,
  output int                              failures,
  output int                              pending,
  output int                              checked
);

  typedef struct {
    logic [MASK_BITS-1:0]       pix;
    logic signed [VAL_BITS-1:0] val;
    logic signed [VEL_BITS-1:0] vel;
    logic [COL_BITS-1:0]        c;
    logic [ROW_BITS-1:0]        r;
  } cell_result_t;

  logic signed [VAL_BITS-1:0] value_mem [0:BOARD_DEPTH-1];
  logic signed [VAL_BITS-1:0] speed_mem [0:BOARD_DEPTH-1];
  logic                       src_bank;
  longint                     damping;
  longint                     mask;
  cell_result_t               awaited_q [$];

  function automatic int cell_addr(logic b, logic [COL_BITS-1:0] c, logic [ROW_BITS-1:0] r);
    return int'({b, r, c});
  endfunction

  // Works out one cell update and writes the new cell into the other board.
  function automatic cell_result_t update_cell(logic [COL_BITS-1:0] c, logic [ROW_BITS-1:0] r);
    cell_result_t res;
    longint centre, sum, diff, v, t, nv;
    logic dst;
    dst    = ~src_bank;
    centre = value_mem[cell_addr(src_bank, c, r)];
    sum    = longint'(value_mem[cell_addr(src_bank, c, r - 1'b1)])
           + longint'(value_mem[cell_addr(src_bank, c - 1'b1, r)])
           + longint'(value_mem[cell_addr(src_bank, c, r + 1'b1)])
           + longint'(value_mem[cell_addr(src_bank, c + 1'b1, r)]);
    diff = (sum >>> 2) - centre;
    v    = longint'(speed_mem[cell_addr(src_bank, c, r)]) + ((64 * diff) >>> 8);
    v    = v + ((damping * v) >>> 8);
    if (v > mask) v = mask;
    else if (v < -mask) v = -mask;
    t  = centre + v;
    nv = t + ((damping * t) >>> 8);
    if (nv > 32767) nv = 32767;
    else if (nv < -32768) nv = -32768;
    value_mem[cell_addr(dst, c, r)] = nv[VAL_BITS-1:0];
    speed_mem[cell_addr(dst, c, r)] = v[VAL_BITS-1:0];
    t = t + (mask >>> 2);
    res.pix = t[MASK_BITS-1:0] & mask[MASK_BITS-1:0];
    res.val = nv[VAL_BITS-1:0];
    res.vel = v[VEL_BITS-1:0];
    res.c   = c;
    res.r   = r;
    return res;
  endfunction

  always @(posedge clk) begin
    cell_result_t want;
    if (rst) begin
      src_bank = 1'b0;
      damping  = 0;
      mask     = 255;
      awaited_q.delete();
      failures = 0;
      checked  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_DAMPING) damping = longint'($signed(cfg_data[DAMP_BITS-1:0]));
        else mask = longint'(cfg_data);
      end
      if (in_valid && !in_stall) begin
        case (kind)
          KIND_LOAD: begin
            value_mem[cell_addr(src_bank, col, row)] = cell_value;
            speed_mem[cell_addr(src_bank, col, row)] = cell_velocity;
          end
          KIND_UPDATE: awaited_q.push_back(update_cell(col, row));
          KIND_SWAP:   src_bank = ~src_bank;
          KIND_POKE:   value_mem[cell_addr(~src_bank, col, row)] = mask[VAL_BITS-1:0];
        endcase
      end
      if (out_valid && !out_stall) begin
        if (awaited_q.size() == 0) begin
          $error("result word arrived with nothing awaited");
          failures++;
        end else begin
          want = awaited_q.pop_front();
          checked++;
          if (pixel_index !== want.pix) begin
            $error("pixel_index: expected %0d, got %0d", want.pix, pixel_index);
            failures++;
          end
          if (new_value !== want.val) begin
            $error("new_value: expected %0d, got %0d", want.val, new_value);
            failures++;
          end
          if (new_velocity !== want.vel) begin
            $error("new_velocity: expected %0d, got %0d", want.vel, new_velocity);
            failures++;
          end
          if (out_col !== want.c) begin
            $error("out_col: expected %0d, got %0d", want.c, out_col);
            failures++;
          end
          if (out_row !== want.r) begin
            $error("out_row: expected %0d, got %0d", want.r, out_row);
            failures++;
          end
        end
      end
    end
    pending = awaited_q.size();
  end

endmodule

### sim/wave_grid_cell_update_unit_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Wave grid cell update unit testbench
// Drives load, update, swap and poke words through several register settings
// with random gaps and back-pressure, and leaves prediction and comparison to
// the checker instantiated beside the unit.
// -----------------------------------------------------------------------------
module wave_grid_cell_update_unit_tb;
  import wgc_pkg::*;

  localparam int IDLE_LIMIT = 3000;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic [KIND_BITS-1:0]       kind;
  logic [COL_BITS-1:0]        col;
  logic [ROW_BITS-1:0]        row;
  logic signed [VAL_BITS-1:0] cell_value;
  logic signed [VAL_BITS-1:0] cell_velocity;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic                       cfg_index;
  logic [MASK_BITS-1:0]       cfg_data;
  logic                       out_valid;
  logic                       out_stall;
  logic [MASK_BITS-1:0]       pixel_index;
  logic signed [VAL_BITS-1:0] new_value;
  logic signed [VEL_BITS-1:0] new_velocity;
  logic [COL_BITS-1:0]        out_col;
  logic [ROW_BITS-1:0]        out_row;
  int                         failures;
  int                         pending;
  int                         checked;

  // The stimulus keeps its own record of which board entries hold a written
  // value and velocity, so that no update ever reads an entry never written.
  bit   value_known [0:BOARD_DEPTH-1];
  bit   speed_known [0:BOARD_DEPTH-1];
  logic drive_bank;
  bit   quick_send;
  bit   quick_take;
  bit   long_hold;
  int   words_sent;

  // The working patch straddles the wrap in both directions, so that most
  // updates reach across the edges of the torus.
  logic [6:0] patch [0:5] = '{7'd125, 7'd126, 7'd127, 7'd0, 7'd1, 7'd2};

  wave_grid_cell_update_unit dut (.*);

  wave_grid_cell_update_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
  end

  function automatic int entry(logic b, logic [6:0] c, logic [6:0] r);
    return int'({b, r, c});
  endfunction

  // Offers one word after a random gap and holds it until it is taken.
  task automatic send_word(logic [1:0] k, logic [6:0] c, logic [6:0] r,
                           logic [15:0] v, logic [15:0] s);
    int gap;
    gap = quick_send ? 0 : $urandom_range(0, 13);
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid      <= 1'b1;
    kind          <= k;
    col           <= c;
    row           <= r;
    cell_value    <= v;
    cell_velocity <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    case (k)
      KIND_LOAD: begin
        value_known[entry(drive_bank, c, r)] = 1'b1;
        speed_known[entry(drive_bank, c, r)] = 1'b1;
      end
      KIND_UPDATE: begin
        value_known[entry(~drive_bank, c, r)] = 1'b1;
        speed_known[entry(~drive_bank, c, r)] = 1'b1;
      end
      KIND_SWAP: drive_bank = ~drive_bank;
      KIND_POKE: value_known[entry(~drive_bank, c, r)] = 1'b1;
    endcase
  endtask

  function automatic bit update_safe(logic [6:0] c, logic [6:0] r);
    return value_known[entry(drive_bank, c, r)] && speed_known[entry(drive_bank, c, r)]
        && value_known[entry(drive_bank, c, r - 1'b1)]
        && value_known[entry(drive_bank, c, r + 1'b1)]
        && value_known[entry(drive_bank, c - 1'b1, r)]
        && value_known[entry(drive_bank, c + 1'b1, r)];
  endfunction

  function automatic logic [15:0] cell_level();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'h7fff;
    if (pick == 1) return 16'h8000;
    if (pick < 4) return 16'($urandom());
    return 16'($signed($urandom_range(0, 800)) - 400);
  endfunction

  task automatic write_reg(logic idx, logic [11:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Waits until every awaited result is back and the unit has had time to
  // finish any trailing load, swap or poke.
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Mostly loads into the patch and legal updates within it, with swaps,
  // pokes and loads scattered over the whole grid as noise.
  task automatic random_words(int count);
    int          pick;
    logic [6:0]  c, r;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      c = patch[$urandom_range(1, 4)];
      r = patch[$urandom_range(1, 4)];
      if (pick < 45) begin
        if (update_safe(c, r)) send_word(KIND_UPDATE, c, r, 16'($urandom()), 16'($urandom()));
        else send_word(KIND_LOAD, c, r, cell_level(), cell_level());
      end else if (pick < 70) begin
        send_word(KIND_LOAD, patch[$urandom_range(0, 5)], patch[$urandom_range(0, 5)],
                  cell_level(), cell_level());
      end else if (pick < 78) begin
        send_word(KIND_LOAD, 7'($urandom()), 7'($urandom()), cell_level(), cell_level());
      end else if (pick < 88) begin
        send_word(KIND_SWAP, 7'($urandom()), 7'($urandom()), 16'($urandom()), 16'($urandom()));
      end else if (pick < 94) begin
        send_word(KIND_POKE, c, r, 16'($urandom()), 16'($urandom()));
      end else begin
        send_word(KIND_POKE, 7'($urandom()), 7'($urandom()), 16'($urandom()),
                  16'($urandom()));
      end
    end
  endtask

  // The receiver draws a stall length for every result word; a long hold
  // lets the unit fill up and push back on the input side.
  initial begin
    int hold;
    out_stall = 1'b1;
    forever begin
      hold = quick_take ? 0 : $urandom_range(0, 13);
      if (long_hold) begin
        hold      = 400;
        long_hold = 1'b0;
      end
      repeat (hold) @(negedge clk) out_stall <= 1'b1;
      @(negedge clk) out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Ends the run if no word moves on any channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [8:0]  damp_set [0:6];
    logic [11:0] mask_set [0:6];
    damp_set      = '{9'd0, 9'h100, 9'h0ff, 9'h100, 9'd0, 9'd0, 9'd0};
    mask_set      = '{12'd4095, 12'd255, 12'd0, 12'd4095, 12'd0, 12'd0, 12'd0};
    in_valid      = 1'b0;
    kind          = KIND_LOAD;
    col           = '0;
    row           = '0;
    cell_value    = '0;
    cell_velocity = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_DAMPING;
    cfg_data      = '0;
    drive_bank    = 1'b0;
    quick_send    = 1'b0;
    quick_take    = 1'b0;
    long_hold     = 1'b0;
    words_sent    = 0;
    @(negedge clk);
    while (rst) @(negedge clk);

    // Directed part under the reset settings: a cross around the corner cell
    // loaded with extreme values, an update that wraps both ways, a poke of
    // its new cell, then a swap so that the poked value is read back.
    send_word(KIND_LOAD, 7'd0,   7'd0,   16'h7fff, 16'h7fff);
    send_word(KIND_LOAD, 7'd127, 7'd0,   16'h8000, 16'h8000);
    send_word(KIND_LOAD, 7'd1,   7'd0,   16'h7fff, 16'h0000);
    send_word(KIND_LOAD, 7'd0,   7'd127, 16'h8000, 16'hffff);
    send_word(KIND_LOAD, 7'd0,   7'd1,   16'h0000, 16'h0001);
    send_word(KIND_UPDATE, 7'd0, 7'd0, 16'h0000, 16'h0000);
    send_word(KIND_POKE, 7'd0, 7'd0, 16'hffff, 16'hffff);
    send_word(KIND_POKE, 7'd127, 7'd127, 16'h0000, 16'h0000);
    send_word(KIND_SWAP, 7'd127, 7'd127, 16'hffff, 16'hffff);
    send_word(KIND_LOAD, 7'd127, 7'd0,   16'h0100, 16'h8000);
    send_word(KIND_LOAD, 7'd1,   7'd0,   16'h8000, 16'h7fff);
    send_word(KIND_LOAD, 7'd0,   7'd127, 16'h7fff, 16'h7fff);
    send_word(KIND_LOAD, 7'd0,   7'd1,   16'h0000, 16'h0000);
    send_word(KIND_UPDATE, 7'd0, 7'd0, 16'hffff, 16'hffff);
    send_word(KIND_SWAP, 7'd0, 7'd0, 16'h0000, 16'h0000);
    random_words(120);
    drain();

    // Fixed extremes first, then random settings. The second phase starts
    // with a long hold on the result side, and two phases run without gaps.
    for (int phase = 0; phase < 7; phase++) begin
      if (phase >= 4) begin
        damp_set[phase] = 9'($urandom());
        mask_set[phase] = 12'($urandom());
      end
      write_reg(REG_DAMPING, {3'b000, damp_set[phase]});
      write_reg(REG_MASK, mask_set[phase]);
      quick_send = (phase == 2 || phase == 5);
      quick_take = (phase == 2 || phase == 6);
      long_hold  = (phase == 1);
      random_words(150);
      drain();
    end

    $display("Sent %0d words and checked %0d update results over eight register settings,",
             words_sent, checked);
    $display("including wrap-around, saturation, clamping and a long output hold.");
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/wgc_pkg.sv
hw/rtl/wgc_ram.sv
hw/rtl/wgc_ctrl.sv
hw/rtl/wgc_datapath.sv
hw/rtl/wave_grid_cell_update_unit.sv
sim/wave_grid_cell_update_checker.sv
sim/wave_grid_cell_update_unit_tb.sv
